// ----- hdl/rst_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rst_pkg
// Shared codes and widths for the record slot table.
// ----------------------------------------------------------------------------
package rst_pkg;
  localparam int SLOTS_DEF     = 16;
  localparam int KEY_CHARS_DEF = 8;
  localparam int MAX_RESULTS   = 16;
  localparam logic [15:0] ID_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    REQ_ADD    = 3'd0,
    REQ_UPD_FN = 3'd1,
    REQ_UPD_LN = 3'd2,
    REQ_REMOVE = 3'd3,
    REQ_LIST   = 3'd4,
    REQ_SORT   = 3'd5,
    REQ_RSV6   = 3'd6,
    REQ_RSV7   = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SLOT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_IDS_OUT   = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SORT_RD, S_SORT_LOAD, S_SORT_JRD,
    S_SORT_CMP, S_SORT_WB, S_LIST_RD, S_LIST_OUT
  } fsm_t;
endpackage
`default_nettype wire

// ----- hdl/record_slot_table_with_sort.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// record_slot_table_with_sort
// Record table in a synchronous memory with scan, update and an
// in-place exchange sort driven by a sequencer.
// ----------------------------------------------------------------------------
// channel   direction  handshake
// request   in         start & !busy transfers req_type/entry_id/keys
// result    out        done high for a single cycle per result, final_item on last
//
// Add answers the cycle after its transfer and leaves busy low. Update and
// remove scan the memory slot by slot, one read state and one check state
// each, up to the hit or the last slot. List reads slot by slot up to the
// last occupied one or MAX_RESULTS results. Sorted list first runs the
// exchange sort, paced by the single read port with one compare per slot.
// Occupied and written marks and the id counter clear on reset; the memory
// itself is not cleared. The receiver cannot stall; busy stays high until
// the last result is out.
// ----------------------------------------------------------------------------
module record_slot_table_with_sort #(
  parameter int SLOTS     = rst_pkg::SLOTS_DEF,
  parameter int KEY_CHARS = rst_pkg::KEY_CHARS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  req_type,
  input  wire logic [15:0] entry_id,
  input  wire logic [63:0] first_name,
  input  wire logic [63:0] last_name,
  output logic             done,
  output logic [2:0]       status,
  output logic [15:0]      record_id,
  output logic [63:0]      record_first,
  output logic [63:0]      record_last,
  output logic             final_item
);
  import rst_pkg::*;

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KW = 8 * KEY_CHARS;
  localparam int EW = 16 + 2 * KW;
  localparam int NW = $clog2(MAX_RESULTS + 1);

  // memory entry: {id, first, last}
  logic [EW-1:0] mem [SLOTS];
  logic [EW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  fsm_t             state, state_next;
  req_t             req, req_next;
  logic [15:0]      eid, eid_next;
  logic [KW-1:0]    fk, fk_next, lk, lk_next;
  logic [AW-1:0]    idx_i, idx_i_next, idx_j, idx_j_next;
  logic [EW-1:0]    ent_i, ent_i_next;
  logic [NW-1:0]    n_out, n_out_next;
  logic [SLOTS-1:0] occ, occ_next, wrt, wrt_next;
  logic [15:0]      id_counter, id_counter_next;
  logic             done_next, final_next;
  logic [2:0]       status_next;
  logic [15:0]      record_id_next;
  logic [63:0]      first_next, last_next;

  wire [15:0]    rd_id    = rd_data[EW-1 -: 16];
  wire [KW-1:0]  rd_first = rd_data[2*KW-1 -: KW];
  wire [KW-1:0]  rd_last  = rd_data[KW-1:0];
  wire [KW-1:0]  i_first  = ent_i[2*KW-1 -: KW];
  wire [KW-1:0]  i_last   = ent_i[KW-1:0];

  // lowest free slot, valid flag
  logic          free_ok;
  logic [AW-1:0] free_idx;
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (!occ[k]) begin
        free_ok  = 1'b1;
        free_idx = AW'(k);
      end
    end
  end

  // swap when entry j (on the read port) ranks before entry i (held in ent_i)
  logic swap;
  always_comb begin
    if (!occ[idx_i])      swap = occ[idx_j];
    else if (!occ[idx_j]) swap = 1'b0;
    else if (i_last != rd_last) swap = i_last > rd_last;
    else swap = i_first > rd_first;
  end

  wire scan_match = (req == REQ_REMOVE) ? (wrt[idx_j] && rd_id == eid)
                                        : (occ[idx_j] && rd_id == eid);

  // any occupied slot beyond the one being listed
  wire [SLOTS-1:0] occ_above = (occ >> idx_j) >> 1;
  wire             has_more  = |occ_above;
  wire             list_last = (n_out == NW'(MAX_RESULTS - 1)) || !has_more;

  assign busy = (state != S_IDLE);

  always_comb begin
    rd_addr = idx_j;
    if (state == S_SORT_RD) rd_addr = idx_i;
  end

  always_comb begin
    state_next      = state;
    req_next        = req;
    eid_next        = eid;
    fk_next         = fk;
    lk_next         = lk;
    idx_i_next      = idx_i;
    idx_j_next      = idx_j;
    ent_i_next      = ent_i;
    n_out_next      = n_out;
    occ_next        = occ;
    wrt_next        = wrt;
    id_counter_next = id_counter;
    done_next       = 1'b0;
    final_next      = final_item;
    status_next     = status;
    record_id_next  = record_id;
    first_next      = record_first;
    last_next       = record_last;
    wr_en           = 1'b0;
    wr_addr         = idx_j;
    wr_data         = ent_i;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          req_next   = req_t'(req_type);
          eid_next   = entry_id;
          fk_next    = first_name[KW-1:0];
          lk_next    = last_name[KW-1:0];
          idx_i_next = '0;
          idx_j_next = '0;
          n_out_next = '0;
          unique case (req_t'(req_type)) inside
            REQ_ADD: begin
              done_next      = 1'b1;
              final_next     = 1'b1;
              record_id_next = '0;
              first_next     = '0;
              last_next      = '0;
              if (!free_ok) status_next = ST_NO_SLOT;
              else if (id_counter == ID_MAX) status_next = ST_IDS_OUT;
              else begin
                status_next     = ST_OK;
                id_counter_next = id_counter + 16'd1;
                record_id_next  = id_counter + 16'd1;
                first_next      = 64'(first_name[KW-1:0]);
                last_next       = 64'(last_name[KW-1:0]);
                wr_en           = 1'b1;
                wr_addr         = free_idx;
                wr_data         = {id_counter + 16'd1, first_name[KW-1:0],
                                   last_name[KW-1:0]};
                occ_next[free_idx] = 1'b1;
                wrt_next[free_idx] = 1'b1;
              end
            end
            REQ_UPD_FN, REQ_UPD_LN, REQ_REMOVE: state_next = S_SCAN_RD;
            REQ_LIST: state_next = S_LIST_RD;
            REQ_SORT: begin
              idx_j_next = AW'(1);
              state_next = S_SORT_RD;
            end
            default: ;
          endcase
        end
      end
      // scan: address idx_j issued, data arrives next cycle
      S_SCAN_RD: state_next = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (scan_match) begin
          done_next      = 1'b1;
          final_next     = 1'b1;
          status_next    = ST_OK;
          record_id_next = eid;
          first_next     = 64'(rd_first);
          last_next      = 64'(rd_last);
          if (req == REQ_REMOVE) occ_next[idx_j] = 1'b0;
          else if (req == REQ_UPD_FN) begin
            wr_en      = 1'b1;
            wr_data    = {rd_id, fk, rd_last};
            first_next = 64'(fk);
          end else begin
            wr_en     = 1'b1;
            wr_data   = {rd_id, rd_first, lk};
            last_next = 64'(lk);
          end
          state_next = S_IDLE;
        end else if (idx_j == AW'(SLOTS - 1)) begin
          done_next      = 1'b1;
          final_next     = 1'b1;
          status_next    = ST_NOT_FOUND;
          record_id_next = eid;
          first_next     = '0;
          last_next      = '0;
          state_next     = S_IDLE;
        end else begin
          idx_j_next = idx_j + AW'(1);
          state_next = S_SCAN_RD;
        end
      end
      // sort: hold entry i in ent_i, sweep j with one read and one compare state per slot
      S_SORT_RD: state_next = S_SORT_LOAD;
      S_SORT_LOAD: begin
        ent_i_next = rd_data;
        state_next = S_SORT_JRD;
      end
      S_SORT_JRD: state_next = S_SORT_CMP;
      S_SORT_CMP: begin
        if (swap) begin
          wr_en      = 1'b1;
          wr_data    = ent_i;
          ent_i_next = rd_data;
          occ_next[idx_j] = occ[idx_i];
          occ_next[idx_i] = occ[idx_j];
          wrt_next[idx_j] = wrt[idx_i];
          wrt_next[idx_i] = wrt[idx_j];
        end
        if (idx_j == AW'(SLOTS - 1)) state_next = S_SORT_WB;
        else begin
          idx_j_next = idx_j + AW'(1);
          state_next = S_SORT_JRD;
        end
      end
      S_SORT_WB: begin
        // write back entry i, advance i
        wr_en   = 1'b1;
        wr_addr = idx_i;
        wr_data = ent_i;
        if (idx_i == AW'(SLOTS - 2)) begin
          idx_j_next = '0;
          state_next = S_LIST_RD;
        end else begin
          idx_i_next = idx_i + AW'(1);
          idx_j_next = idx_i + AW'(2);
          state_next = S_SORT_RD;
        end
      end
      S_LIST_RD: state_next = S_LIST_OUT;
      S_LIST_OUT: begin
        if (occ[idx_j]) begin
          done_next      = 1'b1;
          final_next     = list_last;
          status_next    = ST_OK;
          record_id_next = rd_id;
          first_next     = 64'(rd_first);
          last_next      = 64'(rd_last);
          n_out_next     = n_out + NW'(1);
        end
        if (occ[idx_j] && list_last) state_next = S_IDLE;
        else if (!occ[idx_j] && !has_more) begin
          // nothing was listed before, so the table is empty
          done_next      = 1'b1;
          final_next     = 1'b1;
          status_next    = ST_EMPTY;
          record_id_next = '0;
          first_next     = '0;
          last_next      = '0;
          state_next     = S_IDLE;
        end else begin
          idx_j_next = idx_j + AW'(1);
          state_next = S_LIST_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      req          <= REQ_ADD;
      eid          <= '0;
      fk           <= '0;
      lk           <= '0;
      idx_i        <= '0;
      idx_j        <= '0;
      ent_i        <= '0;
      n_out        <= '0;
      occ          <= '0;
      wrt          <= '0;
      id_counter   <= '0;
      done         <= 1'b0;
      final_item   <= 1'b0;
      status       <= ST_OK;
      record_id    <= '0;
      record_first <= '0;
      record_last  <= '0;
    end else begin
      state        <= state_next;
      req          <= req_next;
      eid          <= eid_next;
      fk           <= fk_next;
      lk           <= lk_next;
      idx_i        <= idx_i_next;
      idx_j        <= idx_j_next;
      ent_i        <= ent_i_next;
      n_out        <= n_out_next;
      occ          <= occ_next;
      wrt          <= wrt_next;
      id_counter   <= id_counter_next;
      done         <= done_next;
      final_item   <= final_next;
      status       <= status_next;
      record_id    <= record_id_next;
      record_first <= first_next;
      record_last  <= last_next;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done && !final_item |-> busy) else $error("non-final result while idle");
  a_add_ok: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_OK && $past(state) == S_IDLE |-> record_id == id_counter)
    else $error("add id mismatch");
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy && req_type == REQ_ADD |=> done && final_item)
    else $error("add without a result");
endmodule
`default_nettype wire
